FILE: rtl/core/stepped_freq_governor_defines.svh
// ----------------------------------------------------------------------------
// stepped frequency governor assertion macros
// shared property forms for the concurrent checks of the governor core
// ----------------------------------------------------------------------------
`ifndef STEPPED_FREQ_GOVERNOR_DEFINES_SVH
`define STEPPED_FREQ_GOVERNOR_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define SFG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is held
`define SFG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sfg_pkg.sv
// ----------------------------------------------------------------------------
// sfg_pkg
// constants, register indexes and helpers for the stepped frequency governor
// ----------------------------------------------------------------------------
`default_nettype none

package sfg_pkg;

	// depth of the efficient step tables
	localparam int MAX_STEPS = 8;

	// configuration register indexes
	localparam logic [2:0] REG_FMAX       = 3'd0;
	localparam logic [2:0] REG_RATE_LIMIT = 3'd1;
	localparam logic [2:0] REG_NUM_FREQ   = 3'd2;
	localparam logic [2:0] REG_NUM_DELAY  = 3'd3;
	localparam logic [2:0] REG_UPD_LIMITS = 3'd4;

	// saturated frequency request
	localparam logic [23:0] FREQ_SAT = 24'hFFFFFF;

	typedef logic [2:0]  step_t;
	typedef logic [23:0] freq_t;
	typedef logic [31:0] delay_t;

	// clamp a step count into one to the table depth
	function automatic logic [3:0] clamp_count(input logic [3:0] n);
		logic [3:0] r;
		r = n;
		if (n == 4'd0) r = 4'd1;
		if (n > 4'(MAX_STEPS)) r = 4'(MAX_STEPS);
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/stepped_freq_governor.sv
// ----------------------------------------------------------------------------
// stepped_freq_governor: a table write is done in idle; a rate-blocked update
// returns to idle; others multiply, run a 24-bit bit-serial divider, may scan
// up to 8 steps. One item at a time; the result sits in an output register and
// the next item is taken meanwhile, a later result waits while it is still full
// async active-low reset clears config, state and both step tables at once
// ----------------------------------------------------------------------------
`default_nettype none
`include "stepped_freq_governor_defines.svh"

module stepped_freq_governor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [63:0] time_ns,
	input  logic [11:0] utilization,
	input  logic [11:0] capacity,
	input  logic        limits_event,
	input  logic [2:0]  entry_index,
	input  logic [23:0] entry_freq_khz,
	input  logic [31:0] entry_delay_ns,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] target_freq_khz,
	output logic [2:0]  step_now
);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RATE = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_DIVS = 4'd3;
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_LIM  = 4'd5;
	localparam logic [3:0] ST_WIN  = 4'd6;
	localparam logic [3:0] ST_UNLK = 4'd7;
	localparam logic [3:0] ST_SCAN = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;
	localparam logic [3:0] ST_EMIT = 4'd10;

	logic [3:0]            state_q;

	// configuration registers
	sfg_pkg::freq_t        fmax_q;
	logic [31:0]           rate_limit_q;
	logic [3:0]            num_freq_q;
	logic [3:0]            num_delay_q;
	logic                  upd_limits_q;

	// governor state
	sfg_pkg::step_t        step_q;
	logic [63:0]           fht_q;
	logic [63:0]           last_change_q;
	sfg_pkg::freq_t        last_target_q;
	sfg_pkg::freq_t        cached_q;
	logic                  pending_q;
	logic                  force_q;
	sfg_pkg::freq_t        freq_tbl_q [sfg_pkg::MAX_STEPS];
	sfg_pkg::delay_t       delay_tbl_q [sfg_pkg::MAX_STEPS];

	// item payload and datapath
	logic [63:0]           time_q;
	logic [11:0]           util_q;
	logic [11:0]           cap_q;
	logic [36:0]           prod_q;
	logic [11:0]           rem_q;
	sfg_pkg::freq_t        freq_q;
	logic [4:0]            bit_cnt_q;
	sfg_pkg::step_t        scan_q;
	logic [63:0]           win_end_q;

	// output register
	logic                  out_valid_q;
	sfg_pkg::freq_t        out_target_q;
	sfg_pkg::step_t        out_step_q;

	logic                  accept;
	logic                  out_load;
	sfg_pkg::step_t        tbl_addr;
	sfg_pkg::freq_t        tbl_freq;
	sfg_pkg::delay_t       tbl_delay;
	logic [3:0]            nf_cnt;
	logic [3:0]            nd_cnt;
	sfg_pkg::step_t        nf_m1;
	sfg_pkg::step_t        nd_m1;
	logic [3:0]            step_inc;
	logic                  can_unlock;
	logic [12:0]           util_adj;
	logic [63:0]           time_diff;
	logic                  rate_block;
	logic [12:0]           div_trial;
	logic                  div_ge;
	logic [12:0]           div_sub;
	logic                  div_sat;
	sfg_pkg::freq_t        fin_next;
	logic                  fin_emit;

	// handshakes
	assign cfg_ready       = 1'b1;
	assign in_ready        = (state_q == ST_IDLE);
	assign accept          = in_valid & in_ready;
	assign out_valid       = out_valid_q;
	assign target_freq_khz = out_target_q;
	assign step_now        = out_step_q;
	// result moves into the output register once that is free
	assign out_load        = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// single table read port, scan counter during the drop search
	assign tbl_addr  = (state_q == ST_SCAN) ? scan_q : step_q;
	assign tbl_freq  = freq_tbl_q[tbl_addr];
	assign tbl_delay = delay_tbl_q[tbl_addr];

	// step counts and unlock test
	assign nf_cnt     = sfg_pkg::clamp_count(num_freq_q);
	assign nd_cnt     = sfg_pkg::clamp_count(num_delay_q);
	assign nf_m1      = 3'(nf_cnt - 4'd1);
	assign nd_m1      = 3'(nd_cnt - 4'd1);
	assign step_inc   = {1'b0, step_q} + 4'd1;
	assign can_unlock = (step_inc <= {1'b0, nf_m1}) && (step_inc <= {1'b0, nd_m1});

	// rate limit, utilisation headroom
	assign util_adj   = {1'b0, util_q} + {3'b000, util_q[11:2]};
	assign time_diff  = time_q - last_change_q;
	assign rate_block = time_diff[63] || (time_diff < {32'd0, rate_limit_q});

	// one restoring divide step; quotient bits shift in behind the dividend
	assign div_trial = {rem_q, freq_q[23]};
	assign div_ge    = (div_trial >= {1'b0, cap_q});
	assign div_sub   = div_trial - {1'b0, cap_q};
	// quotient overflows 24 bits, also covers zero capacity
	assign div_sat   = (prod_q[36:24] >= {1'b0, cap_q});

	// change filter
	assign fin_next = (freq_q == cached_q && !force_q) ? last_target_q : freq_q;
	assign fin_emit = force_q ? !(last_target_q == fin_next && !upd_limits_q)
	                          : (last_target_q != fin_next);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmax_q       <= '0;
			rate_limit_q <= '0;
			num_freq_q   <= 4'd1;
			num_delay_q  <= 4'd1;
			upd_limits_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sfg_pkg::REG_FMAX:       fmax_q       <= cfg_data[23:0];
				sfg_pkg::REG_RATE_LIMIT: rate_limit_q <= cfg_data;
				sfg_pkg::REG_NUM_FREQ:   num_freq_q   <= cfg_data[3:0];
				sfg_pkg::REG_NUM_DELAY:  num_delay_q  <= cfg_data[3:0];
				sfg_pkg::REG_UPD_LIMITS: upd_limits_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// step tables, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfg_pkg::MAX_STEPS; i++) begin
				freq_tbl_q[i]  <= '0;
				delay_tbl_q[i] <= '0;
			end
		end else if (accept && func && ({1'b0, entry_index} < 4'(sfg_pkg::MAX_STEPS))) begin
			freq_tbl_q[entry_index]  <= entry_freq_khz;
			delay_tbl_q[entry_index] <= entry_delay_ns;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			time_q <= time_ns;
			util_q <= utilization;
			cap_q  <= capacity;
		end
		case (state_q)
			ST_MUL: begin
				prod_q <= 37'(fmax_q) * 37'(util_adj);
			end
			ST_DIVS: begin
				if (div_sat) begin
					freq_q <= sfg_pkg::FREQ_SAT;
				end else begin
					rem_q     <= prod_q[35:24];
					freq_q    <= prod_q[23:0];
					bit_cnt_q <= 5'd23;
				end
			end
			ST_DIV: begin
				rem_q     <= div_ge ? div_sub[11:0] : div_trial[11:0];
				freq_q    <= {freq_q[22:0], div_ge};
				bit_cnt_q <= bit_cnt_q - 5'd1;
			end
			ST_LIM: begin
				if (freq_q > tbl_freq && fht_q == 64'd0) begin
					freq_q <= tbl_freq;
				end else if (freq_q < tbl_freq) begin
					scan_q <= '0;
				end else begin
					win_end_q <= fht_q + {32'd0, tbl_delay};
				end
			end
			ST_WIN: begin
				if (fht_q != 64'd0 && time_q < win_end_q) freq_q <= tbl_freq;
			end
			ST_UNLK: begin
				if (freq_q > tbl_freq) freq_q <= tbl_freq;
			end
			ST_SCAN: begin
				scan_q <= scan_q + 3'd1;
			end
			ST_EMIT: begin
				if (out_load) begin
					out_target_q <= last_target_q;
					out_step_q   <= step_q;
				end
			end
			default: ;
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			fht_q         <= '0;
			last_change_q <= '0;
			last_target_q <= '0;
			cached_q      <= '0;
			pending_q     <= 1'b0;
			force_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func) begin
							// table write, step falls back to the lowest entry
							step_q    <= '0;
							pending_q <= pending_q | limits_event;
						end else if (pending_q || limits_event) begin
							// limits event skips the rate limit
							pending_q <= 1'b0;
							force_q   <= 1'b1;
							state_q   <= ST_MUL;
						end else begin
							state_q <= ST_RATE;
						end
					end
				end
				ST_RATE: begin
					state_q <= rate_block ? ST_IDLE : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DIVS;
				end
				ST_DIVS: begin
					state_q <= div_sat ? ST_LIM : ST_DIV;
				end
				ST_DIV: begin
					if (bit_cnt_q == 5'd0) state_q <= ST_LIM;
				end
				ST_LIM: begin
					if (freq_q > tbl_freq && fht_q == 64'd0) begin
						// first high request opens the up-delay window
						fht_q   <= time_q;
						state_q <= ST_FIN;
					end else if (freq_q < tbl_freq) begin
						fht_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (fht_q != 64'd0 && time_q < win_end_q) begin
						state_q <= ST_FIN;
					end else if (can_unlock) begin
						step_q  <= 3'(step_inc);
						fht_q   <= time_q;
						state_q <= ST_UNLK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_UNLK: begin
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					// lowest step that still covers the request
					if (tbl_freq >= freq_q) begin
						step_q  <= scan_q;
						state_q <= ST_FIN;
					end else if (scan_q == nf_m1) begin
						step_q  <= nf_m1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (freq_q != cached_q || force_q) cached_q <= freq_q;
					force_q <= 1'b0;
					if (fin_emit) begin
						last_target_q <= fin_next;
						last_change_q <= time_q;
						state_q       <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`SFG_ASSERT_NOW(a_div_rem_below_cap, state_q == ST_DIV, rem_q < cap_q,
		"divider remainder not below capacity")
	`SFG_ASSERT_NEXT(a_write_resets_step, accept && func, step_q == 3'd0,
		"table write did not reset the step")
	`SFG_ASSERT_NEXT(a_emit_loads_output, state_q == ST_EMIT && (!out_valid_q || out_ready),
		out_valid_q && in_ready, "emit did not load the output register")

endmodule

`default_nettype wire

FILE: tb/sv/stepped_freq_governor_checker.sv
// ----------------------------------------------------------------------------
// stepped frequency governor checker
// watches the register, item and result channels, keeps its own copy of the
// governor state and compares every result with the oldest prediction
// ----------------------------------------------------------------------------
module stepped_freq_governor_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [63:0] time_ns,
	input  logic [11:0] utilization,
	input  logic [11:0] capacity,
	input  logic        limits_event,
	input  logic [2:0]  entry_index,
	input  logic [23:0] entry_freq_khz,
	input  logic [31:0] entry_delay_ns,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] target_freq_khz,
	input  logic [2:0]  step_now,
	output int          fails,
	output int          pending,
	output int          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// beyond this many mismatches only the count goes on
	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		sfg_pkg::freq_t freq;
		sfg_pkg::step_t step;
	} target_t;

	// predicted results, oldest first
	target_t target_q[$];

	// register copy
	sfg_pkg::freq_t  fmax;
	logic [31:0]     rate_limit;
	logic [3:0]      freq_steps;
	logic [3:0]      delay_steps;
	logic            limits_upd;

	// governor state copy
	sfg_pkg::step_t  cur_step;
	logic [63:0]     high_since;
	logic [63:0]     changed_at;
	sfg_pkg::freq_t  last_tgt;
	sfg_pkg::freq_t  last_req;
	logic            limits_pend;
	logic            forced;
	sfg_pkg::freq_t  step_freq [sfg_pkg::MAX_STEPS];
	sfg_pkg::delay_t step_delay [sfg_pkg::MAX_STEPS];

	task automatic report(string msg);
		if (fails < MAX_PRINTED)
			$display("%0t ns mismatch: %s", $realtime, msg);
		fails++;
	endtask

	// step count as the limiter uses it
	function automatic int eff_count(logic [3:0] n);
		if (n == 4'd0)
			return 1;
		if (int'(n) > sfg_pkg::MAX_STEPS)
			return sfg_pkg::MAX_STEPS;
		return int'(n);
	endfunction

	// lowest step whose frequency still covers the request
	function automatic sfg_pkg::step_t fitting_step(sfg_pkg::freq_t f, int nf);
		for (int i = 0; i < nf; i++)
			if (step_freq[i] >= f)
				return sfg_pkg::step_t'(i);
		return sfg_pkg::step_t'(nf - 1);
	endfunction

	// cap the raw request at the efficient step, climbing when the up-delay allows
	function automatic sfg_pkg::freq_t capped_request(sfg_pkg::freq_t f, logic [63:0] t);
		int             nf;
		int             nd;
		sfg_pkg::freq_t ef;
		logic [63:0]    open_at;
		nf = eff_count(freq_steps);
		nd = eff_count(delay_steps);
		ef = step_freq[cur_step];
		if (f > ef && high_since == 64'd0) begin
			high_since = t;
			return ef;
		end
		if (f < ef) begin
			cur_step = fitting_step(f, nf);
			high_since = 64'd0;
			return f;
		end
		// window end wraps modulo 2^64
		open_at = high_since + 64'(step_delay[cur_step]);
		if (high_since != 64'd0 && t < open_at)
			return ef;
		if (int'(cur_step) + 1 <= nf - 1 && int'(cur_step) + 1 <= nd - 1) begin
			cur_step = cur_step + sfg_pkg::step_t'(1);
			high_since = t;
			ef = step_freq[cur_step];
			if (f > ef)
				f = ef;
		end
		return f;
	endfunction

	// one accepted item: update the state and queue the result it causes
	task automatic governor_step();
		logic [63:0]    t;
		logic [63:0]    since;
		logic [12:0]    u;
		logic [63:0]    raw;
		sfg_pkg::freq_t f;
		sfg_pkg::freq_t nxt;
		target_t        e;
		if (limits_event)
			limits_pend = 1'b1;
		// table write: no result, step back to the bottom
		if (func) begin
			step_freq[entry_index] = entry_freq_khz;
			step_delay[entry_index] = entry_delay_ns;
			cur_step = '0;
			return;
		end
		t = time_ns;
		// rate limit, bypassed by a pending limits event
		if (limits_pend) begin
			limits_pend = 1'b0;
			forced = 1'b1;
		end else begin
			since = t - changed_at;
			if (since[63] || since < 64'(rate_limit))
				return;
		end
		// raw request with 25% headroom, saturated to 24 bits
		u = 13'(utilization) + 13'(utilization >> 2);
		if (capacity == 12'd0) begin
			raw = 64'(sfg_pkg::FREQ_SAT);
		end else begin
			raw = (64'(fmax) * 64'(u)) / 64'(capacity);
			if (raw > 64'(sfg_pkg::FREQ_SAT))
				raw = 64'(sfg_pkg::FREQ_SAT);
		end
		f = capped_request(sfg_pkg::freq_t'(raw), t);
		if (f == last_req && !forced) begin
			nxt = last_tgt;
		end else begin
			last_req = f;
			nxt = f;
		end
		if (forced) begin
			forced = 1'b0;
			if (last_tgt == nxt && !limits_upd)
				return;
		end else if (last_tgt == nxt) begin
			return;
		end
		last_tgt = nxt;
		changed_at = t;
		e.freq = nxt;
		e.step = cur_step;
		target_q.push_back(e);
	endtask

	task automatic apply_reg();
		case (cfg_index)
			sfg_pkg::REG_FMAX:       fmax = cfg_data[23:0];
			sfg_pkg::REG_RATE_LIMIT: rate_limit = cfg_data;
			sfg_pkg::REG_NUM_FREQ:   freq_steps = cfg_data[3:0];
			sfg_pkg::REG_NUM_DELAY:  delay_steps = cfg_data[3:0];
			sfg_pkg::REG_UPD_LIMITS: limits_upd = cfg_data[0];
			default: ;
		endcase
	endtask

	task automatic check_result();
		target_t e;
		if (target_q.size() == 0) begin
			report($sformatf("result %0d step %0d with no item waiting",
				target_freq_khz, step_now));
			return;
		end
		e = target_q.pop_front();
		if (target_freq_khz !== e.freq)
			report($sformatf("target_freq_khz expected %0d got %0d", e.freq, target_freq_khz));
		if (step_now !== e.step)
			report($sformatf("step_now expected %0d got %0d", e.step, step_now));
		checked++;
	endtask

	// sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmax = '0;
			rate_limit = '0;
			freq_steps = 4'd1;
			delay_steps = 4'd1;
			limits_upd = 1'b0;
			cur_step = '0;
			high_since = '0;
			changed_at = '0;
			last_tgt = '0;
			last_req = '0;
			limits_pend = 1'b0;
			forced = 1'b0;
			for (int i = 0; i < sfg_pkg::MAX_STEPS; i++) begin
				step_freq[i] = '0;
				step_delay[i] = '0;
			end
			target_q.delete();
			fails = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_valid && cfg_ready)
				apply_reg();
			if (in_valid && in_ready)
				governor_step();
			pending = target_q.size();
		end
	end

endmodule

FILE: tb/sv/stepped_freq_governor_tb.sv
// ----------------------------------------------------------------------------
// stepped frequency governor testbench
// directed corner items, then random utilization traffic over several
// register settings, with random gaps on both sides and one long output stall
// ----------------------------------------------------------------------------
module stepped_freq_governor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles allowed with no handshake on any channel
	localparam int QUIET_LIMIT = 5000;
	// cycles to let an item with no result finish before a register write
	localparam int DRAIN_CYCLES = 48;
	// long output stall
	localparam int HOLD_CYCLES = 300;
	localparam int N_PHASES = 6;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [63:0] time_ns;
	logic [11:0] utilization;
	logic [11:0] capacity;
	logic        limits_event;
	logic [2:0]  entry_index;
	logic [23:0] entry_freq_khz;
	logic [31:0] entry_delay_ns;
	logic        out_valid;
	logic        out_ready;
	logic [23:0] target_freq_khz;
	logic [2:0]  step_now;

	int fails;
	int pending;
	int checked;

	int          n_items;
	int          n_writes;
	int          quiet;
	bit          send_calm;
	bit          hold_req;
	bit          hold_done;
	logic [63:0] now;
	logic [11:0] last_util;
	logic [11:0] last_cap;

	stepped_freq_governor u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.time_ns        (time_ns),
		.utilization    (utilization),
		.capacity       (capacity),
		.limits_event   (limits_event),
		.entry_index    (entry_index),
		.entry_freq_khz (entry_freq_khz),
		.entry_delay_ns (entry_delay_ns),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.target_freq_khz(target_freq_khz),
		.step_now       (step_now)
	);

	stepped_freq_governor_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.time_ns        (time_ns),
		.utilization    (utilization),
		.capacity       (capacity),
		.limits_event   (limits_event),
		.entry_index    (entry_index),
		.entry_freq_khz (entry_freq_khz),
		.entry_delay_ns (entry_delay_ns),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.target_freq_khz(target_freq_khz),
		.step_now       (step_now),
		.fails          (fails),
		.pending        (pending),
		.checked        (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly none or short, now and then long
	function automatic int idle_len(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// progress watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					QUIET_LIMIT, pending);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// result side: random stalls, calm stretches and one long hold-off
	initial begin
		int n;
		bit ready_calm;
		ready_calm = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				ready_calm = !ready_calm;
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				n = idle_len(ready_calm);
				if (n == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (n - 1) @(negedge clk);
				end
			end
		end
	end

	// offer one item and hold it until taken
	task automatic send_item(bit f, logic [63:0] t, logic [11:0] u, logic [11:0] c,
		bit lim, logic [2:0] idx, sfg_pkg::freq_t ef, sfg_pkg::delay_t ed);
		int gap;
		gap = idle_len(send_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		time_ns <= t;
		utilization <= u;
		capacity <= c;
		limits_event <= lim;
		entry_index <= idx;
		entry_freq_khz <= ef;
		entry_delay_ns <= ed;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_items++;
		if (f)
			n_writes++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// let every expected result out and the block fall idle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ascending efficient steps spread up to about the maximum frequency
	task automatic load_table(sfg_pkg::freq_t mf);
		logic [63:0] fq;
		for (int i = 0; i < sfg_pkg::MAX_STEPS; i++) begin
			fq = (64'(mf) * 64'(i + 1)) / 64'(sfg_pkg::MAX_STEPS)
				+ 64'($urandom_range(0, 5000));
			if (fq > 64'(sfg_pkg::FREQ_SAT))
				fq = 64'(sfg_pkg::FREQ_SAT);
			send_item(1'b1, now, 12'($urandom), 12'($urandom), 1'b0, 3'(i),
				sfg_pkg::freq_t'(fq), sfg_pkg::delay_t'($urandom_range(0, 4000)));
		end
	endtask

	// utilization update with a mostly advancing clock
	task automatic random_update(int lim_pct);
		int          r;
		int          cc;
		logic [11:0] u;
		logic [11:0] c;
		r = $urandom_range(0, 99);
		if (r < 3)
			now = now - 64'($urandom_range(1, 4000));
		else if (r < 5)
			now = now + (64'($urandom) << $urandom_range(0, 32));
		else
			now = now + 64'($urandom_range(0, 2500));
		r = $urandom_range(0, 99);
		if (r < 30) begin
			u = last_util;
			c = last_cap;
		end else if (r < 60) begin
			cc = $urandom_range(1, 4095);
			c = 12'(cc);
			u = 12'($urandom_range(cc - cc / 4, 4095));
		end else begin
			c = 12'($urandom_range(1, 4095));
			u = 12'($urandom_range(0, 4095));
		end
		if ($urandom_range(0, 199) == 0)
			c = 12'd0;
		last_util = u;
		last_cap = c;
		send_item(1'b0, now, u, c, $urandom_range(0, 99) < lim_pct, 3'($urandom),
			sfg_pkg::freq_t'($urandom), sfg_pkg::delay_t'($urandom));
	endtask

	// one register setting followed by random traffic
	task automatic run_phase(int p);
		sfg_pkg::freq_t mf;
		logic [31:0]    rl;
		logic [3:0]     nf;
		logic [3:0]     nd;
		bit             uol;
		bit             fresh;
		int             n;
		int             lim_pct;
		mf = sfg_pkg::freq_t'($urandom);
		rl = 32'($urandom_range(0, 3000));
		nf = 4'($urandom_range(0, 15));
		nd = 4'($urandom_range(0, 15));
		uol = 1'($urandom_range(0, 1));
		fresh = 1'b1;
		n = 90;
		lim_pct = 8;
		case (p)
			0: begin
				mf = sfg_pkg::freq_t'($urandom_range(500000, 4000000));
				rl = 32'($urandom_range(0, 1500));
				nf = 4'd8;
				nd = 4'd8;
				uol = 1'b0;
			end
			// counts lowered under a raised step, table left alone
			1: begin
				mf = sfg_pkg::freq_t'($urandom_range(500000, 4000000));
				rl = 32'($urandom_range(0, 800));
				nf = 4'd3;
				nd = 4'd5;
				uol = 1'b0;
				fresh = 1'b0;
				n = 80;
			end
			2: begin
				mf = sfg_pkg::FREQ_SAT;
				rl = 32'd0;
				nf = 4'd15;
				nd = 4'd0;
				uol = 1'b1;
				n = 80;
			end
			// limits events get through here, other updates only after a large jump in time
			3: begin
				mf = '0;
				rl = 32'hFFFF_FFFF;
				nf = 4'd1;
				nd = 4'd9;
				uol = 1'b1;
				n = 60;
				lim_pct = 35;
			end
			default: ;
		endcase
		settle();
		write_reg(sfg_pkg::REG_FMAX, 32'(mf));
		write_reg(sfg_pkg::REG_RATE_LIMIT, rl);
		write_reg(sfg_pkg::REG_NUM_FREQ, 32'(nf));
		write_reg(sfg_pkg::REG_NUM_DELAY, 32'(nd));
		write_reg(sfg_pkg::REG_UPD_LIMITS, 32'(uol));
		if (p >= 4)
			for (int k = int'(sfg_pkg::REG_UPD_LIMITS) + 1; k < 8; k++)
				write_reg(3'(k), $urandom);
		send_calm = ($urandom_range(0, 2) == 0);
		if (fresh)
			load_table(mf);
		if (p == 0)
			hold_req = 1'b1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 5)
				send_item(1'b1, now, 12'($urandom), 12'($urandom),
					$urandom_range(0, 9) == 0, 3'($urandom), sfg_pkg::freq_t'($urandom),
					sfg_pkg::delay_t'($urandom));
			else
				random_update(lim_pct);
			if ($urandom_range(0, 59) == 0)
				send_calm = !send_calm;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = 1'b0;
		time_ns = '0;
		utilization = '0;
		capacity = 12'd1;
		limits_event = 1'b0;
		entry_index = '0;
		entry_freq_khz = '0;
		entry_delay_ns = '0;
		n_items = 0;
		n_writes = 0;
		send_calm = 1'b0;
		hold_req = 1'b0;
		now = 64'd3000;
		last_util = 12'd100;
		last_cap = 12'd100;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero maximum, limits event without update-on-limits
		send_item(1'b0, 64'd100, 12'd100, 12'd100, 1'b0, 3'd0, '0, '0);
		send_item(1'b0, 64'd200, 12'd4095, 12'd4095, 1'b1, 3'd0, '0, '0);
		settle();
		write_reg(sfg_pkg::REG_FMAX, 32'd1000000);
		write_reg(sfg_pkg::REG_RATE_LIMIT, 32'd500);
		write_reg(sfg_pkg::REG_NUM_FREQ, 32'd4);
		write_reg(sfg_pkg::REG_NUM_DELAY, 32'd4);
		write_reg(sfg_pkg::REG_UPD_LIMITS, 32'd1);
		write_reg(sfg_pkg::REG_UPD_LIMITS + 3'd1, 32'hFFFF_FFFF);

		// step table, last entry at its extremes with a limits event latched
		send_item(1'b1, 64'd300, '0, 12'd1, 1'b0, 3'd0, 24'd200000, 32'd0);
		send_item(1'b1, 64'd300, '0, 12'd1, 1'b0, 3'd1, 24'd400000, 32'd1000);
		send_item(1'b1, 64'd300, '0, 12'd1, 1'b0, 3'd2, 24'd700000, 32'd2000);
		send_item(1'b1, 64'd300, '0, 12'd1, 1'b0, 3'd3, 24'd900000, 32'd3000);
		send_item(1'b1, 64'd300, '0, 12'd1, 1'b1, 3'd7, sfg_pkg::FREQ_SAT, 32'hFFFF_FFFF);

		// saturating requests, a rate-limited one, climbing steps
		send_item(1'b0, 64'd1000, 12'd4095, 12'd1, 1'b0, 3'd0, '0, '0);
		send_item(1'b0, 64'd1200, 12'd4095, 12'd1, 1'b0, 3'd0, '0, '0);
		send_item(1'b0, 64'd2000, 12'd4095, 12'd1, 1'b0, 3'd0, '0, '0);
		send_item(1'b0, 64'd4000, 12'd4095, 12'd1, 1'b0, 3'd0, '0, '0);
		// time going backwards, then demand falling away
		send_item(1'b0, 64'd3900, 12'd2000, 12'd2000, 1'b0, 3'd0, '0, '0);
		send_item(1'b0, 64'd6000, 12'd0, 12'd4095, 1'b0, 3'd0, '0, '0);
		// zero capacity, then a drop
		send_item(1'b0, 64'd7000, 12'd100, 12'd0, 1'b0, 3'd0, '0, '0);
		send_item(1'b0, 64'd8000, 12'd0, 12'd100, 1'b0, 3'd0, '0, '0);
		// first high request at time zero, through a limits event
		send_item(1'b0, 64'd0, 12'd4095, 12'd4095, 1'b1, 3'd0, '0, '0);
		// near the top of the time range, up-delay window wrapping
		send_item(1'b0, 64'hFFFF_FFFF_FFFF_FF00, 12'd4095, 12'd4095, 1'b1, 3'd0, '0, '0);
		send_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 12'd4095, 12'd4095, 1'b0, 3'd0, '0, '0);
		send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF, 12'hFFF, 1'b0, 3'd3, '0, '0);
		send_item(1'b0, 64'd2000, 12'd4095, 12'd4095, 1'b0, 3'd0, '0, '0);
		send_item(1'b0, 64'd2600, 12'd1, 12'd4095, 1'b0, 3'd0, '0, '0);

		for (int p = 0; p < N_PHASES; p++)
			run_phase(p);

		// drain
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("sent %0d items, %0d of them step table writes, over %0d register settings",
			n_items, n_writes, N_PHASES + 1);
		$display("checked %0d results; long output hold-off %s", checked,
			hold_done ? "done" : "not reached");
		if (fails == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: stepped_freq_governor.f
+incdir+rtl/core
rtl/core/sfg_pkg.sv
rtl/core/stepped_freq_governor.sv
tb/sv/stepped_freq_governor_checker.sv
tb/sv/stepped_freq_governor_tb.sv
